FILE: rtl/core/mbs_pkg.sv
// ----------------------------------------------------------------------------
// mbs_pkg
// shared constants and types for the bounding sphere block
// ----------------------------------------------------------------------------
package mbs_pkg;
	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 24;
	localparam int RAD_BITS = 25;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_SCAN,
		BK_SQRT,
		BK_OUT
	} bk_state_t;
endpackage

FILE: rtl/core/mbs_stream_if.sv
// ----------------------------------------------------------------------------
// mbs_stream_if
// valid/ready channel with a generic payload
// ----------------------------------------------------------------------------
interface mbs_stream_if #(parameter type payload_t = logic) (input logic clk);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/mbs_ram.sv
// ----------------------------------------------------------------------------
// mbs_ram
// single port write, single port read ram with registered read
// ----------------------------------------------------------------------------
module mbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

FILE: rtl/core/mbs_top_dummy_never.sv
// ----------------------------------------------------------------------------
// mbs_front
// accepts points, stores them and keeps sums, count and box per set
// ----------------------------------------------------------------------------
module mbs_front #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 24,
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	localparam int CW = $clog2(MAX_POINTS + 1),
	localparam int SW = COORD_BITS + CW
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	input  logic signed [COORD_BITS-1:0] pz,
	input  logic                         plast,
	output logic                         we,
	output logic [AW-1:0]                waddr,
	output logic [3*COORD_BITS-1:0]      wdata,
	// set summary handed to the back part
	output logic                         set_valid,
	input  logic                         set_ready,
	output logic [CW-1:0]                set_count,
	output logic signed [SW-1:0]         set_sum [3],
	output logic signed [COORD_BITS-1:0] set_min [3],
	output logic signed [COORD_BITS-1:0] set_max [3],
	output logic                         set_ovf
);
	import mbs_pkg::*;

	localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic [CW-1:0]                cnt_q;
	logic signed [SW-1:0]         sum_q [3];
	logic signed [COORD_BITS-1:0] min_q [3];
	logic signed [COORD_BITS-1:0] max_q [3];
	logic                         ovf_q;
	logic                         pend_q;
	logic signed [COORD_BITS-1:0] p [3];
	logic                         acc, room;

	assign p[0] = px;
	assign p[1] = py;
	assign p[2] = pz;
	// hold off while a finished set waits for the back part
	assign in_ready = !pend_q;
	assign acc = in_valid && in_ready;
	assign room = cnt_q < CW'(MAX_POINTS);
	assign we = acc && room;
	assign waddr = cnt_q[AW-1:0];
	assign wdata = {pz, py, px};

	assign set_valid = pend_q;
	assign set_count = cnt_q;
	assign set_sum = sum_q;
	assign set_min = min_q;
	assign set_max = max_q;
	assign set_ovf = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
			pend_q <= 1'b0;
			for (int a = 0; a < 3; a++) begin
				sum_q[a] <= '0;
				min_q[a] <= CMAX;
				max_q[a] <= CMIN;
			end
		end else begin
			if (pend_q && set_ready) begin
				pend_q <= 1'b0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
				for (int a = 0; a < 3; a++) begin
					sum_q[a] <= '0;
					min_q[a] <= CMAX;
					max_q[a] <= CMIN;
				end
			end else if (acc) begin
				if (room) begin
					cnt_q <= cnt_q + 1'b1;
					for (int a = 0; a < 3; a++) begin
						sum_q[a] <= sum_q[a] + SW'(p[a]);
						if (p[a] < min_q[a])
							min_q[a] <= p[a];
						if (p[a] > max_q[a])
							max_q[a] <= p[a];
					end
				end else begin
					ovf_q <= 1'b1;
				end
				if (plast)
					pend_q <= 1'b1;
			end
		end
	end
endmodule

FILE: rtl/core/mbs_back.sv
// ----------------------------------------------------------------------------
// mbs_back
// forms both centres, scans the store for the farthest points, takes roots
// ----------------------------------------------------------------------------
module mbs_back #(
	parameter int MAX_POINTS = 1024,
	parameter int COORD_BITS = 24,
	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
	localparam int CW = $clog2(MAX_POINTS + 1),
	localparam int SW = COORD_BITS + CW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          set_valid,
	output logic                          set_ready,
	input  logic [CW-1:0]                 set_count,
	input  logic signed [SW-1:0]          set_sum [3],
	input  logic signed [COORD_BITS-1:0]  set_min [3],
	input  logic signed [COORD_BITS-1:0]  set_max [3],
	input  logic                          set_ovf,
	output logic [AW-1:0]                 raddr,
	input  logic [3*COORD_BITS-1:0]       rdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_BITS-1:0]  cx,
	output logic signed [COORD_BITS-1:0]  cy,
	output logic signed [COORD_BITS-1:0]  cz,
	output logic [mbs_pkg::RAD_BITS-1:0]  rad,
	output logic                          used_box,
	output logic                          ovf
);
	import mbs_pkg::*;

	localparam int DW = 2 * COORD_BITS + 4;  // squared distance width, even for the root
	localparam int RW = (DW + 1) / 2;        // root width
	localparam int SQ_STEPS = RW;
	localparam int DIVB = SW;                // quotient bits worked out

	bk_state_t st_q, st_d;

	logic [CW-1:0]                cnt_q;
	logic signed [COORD_BITS-1:0] cen_q [2][3];
	logic                         ovf_q;
	// shift-subtract divider over the three axes in turn
	logic [1:0]                   ax_q;
	logic [$clog2(DIVB+1)-1:0]    dbit_q;
	logic [SW-1:0]                quo_q, rem_q, dmag_q;
	logic                         dneg_q;
	// scan
	logic [CW-1:0]                idx_q;
	logic                         rv_s1;
	logic [DW-1:0]                best_q [2];
	logic signed [COORD_BITS+1:0] dif_s2 [2][3];
	logic                         v_s2;
	logic [2*COORD_BITS+1:0]      sq_s3 [2][3];
	logic                         v_s3;
	// root
	logic [DW-1:0]                rn_q [2];
	logic [RW-1:0]                rr_q [2];
	logic [RW-1:0]                ra_q [2];
	logic [$clog2(SQ_STEPS+1)-1:0] sstep_q;

	logic [SW-1:0] trial;
	logic [SW-1:0] dividend_mag;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (set_valid) st_d = BK_DIV;
			BK_DIV:  if (ax_q == 2'd2 && dbit_q == '0) st_d = BK_SCAN;
			BK_SCAN: if (idx_q == cnt_q && !rv_s1 && !v_s2 && !v_s3) st_d = BK_SQRT;
			BK_SQRT: if (sstep_q == ($clog2(SQ_STEPS+1))'(1)) st_d = BK_OUT;
			BK_OUT:  if (out_ready) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		logic pick;
		pick = !(ra_q[0] < ra_q[1]);
		// summary and store belong to this set until the scan ends
		set_ready = (st_q == BK_SCAN) && (st_d == BK_SQRT);
		out_valid = (st_q == BK_OUT);
		cx = cen_q[pick][0];
		cy = cen_q[pick][1];
		cz = cen_q[pick][2];
		rad = (RW > RAD_BITS && |(ra_q[pick] >> RAD_BITS)) ? '1 : RAD_BITS'(ra_q[pick]);
		used_box = pick;
		ovf = ovf_q;
	end

	assign raddr = idx_q[AW-1:0];
	assign trial = {rem_q[SW-2:0], dmag_q[SW-1]};

	always_comb begin
		logic signed [SW-1:0] s;
		s = set_sum[0];
		dividend_mag = s[SW-1] ? SW'(-s) : s;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			rv_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			st_q <= st_d;
			rv_s1 <= (st_q == BK_SCAN) && (idx_q != cnt_q);
			v_s2 <= rv_s1;
			v_s3 <= v_s2;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		logic signed [SW-1:0] sv;
		logic [SW-1:0]        r2;
		logic [DW-1:0]        tot;
		logic signed [COORD_BITS-1:0] q;
		logic [DW+1:0]        tr;
		case (st_q)
			BK_IDLE: begin
				cnt_q <= set_count;
				ovf_q <= set_ovf;
				for (int a = 0; a < 3; a++)
					cen_q[1][a] <= COORD_BITS'((SW'(set_max[a]) + SW'(set_min[a])) >>> 1);
				ax_q <= '0;
				dbit_q <= ($clog2(DIVB+1))'(DIVB);
				quo_q <= '0;
				rem_q <= '0;
				dmag_q <= dividend_mag;
				dneg_q <= set_sum[0][SW-1];
				idx_q <= '0;
				best_q[0] <= '0;
				best_q[1] <= '0;
			end
			BK_DIV: begin
				// one quotient bit a cycle, sign fixed at the end
				if (dbit_q != '0) begin
					if (trial >= SW'(cnt_q)) begin
						rem_q <= trial - SW'(cnt_q);
						quo_q <= {quo_q[SW-2:0], 1'b1};
					end else begin
						rem_q <= trial;
						quo_q <= {quo_q[SW-2:0], 1'b0};
					end
					dmag_q <= dmag_q << 1;
					dbit_q <= dbit_q - 1'b1;
				end else begin
					q = dneg_q ? COORD_BITS'(-quo_q) : COORD_BITS'(quo_q);
					cen_q[0][ax_q] <= q;
					sv = set_sum[(ax_q == 2'd0) ? 1 : 2];
					dmag_q <= sv[SW-1] ? SW'(-sv) : sv;
					dneg_q <= sv[SW-1];
					quo_q <= '0;
					rem_q <= '0;
					dbit_q <= ($clog2(DIVB+1))'(DIVB);
					ax_q <= ax_q + 1'b1;
				end
			end
			BK_SCAN: begin
				if (idx_q != cnt_q)
					idx_q <= idx_q + 1'b1;
				if (rv_s1) begin
					for (int k = 0; k < 2; k++)
						for (int a = 0; a < 3; a++)
							dif_s2[k][a] <= (COORD_BITS+2)'($signed(
								rdata[a*COORD_BITS +: COORD_BITS]))
								- (COORD_BITS+2)'(cen_q[k][a]);
				end
				if (v_s2) begin
					for (int k = 0; k < 2; k++)
						for (int a = 0; a < 3; a++)
							sq_s3[k][a] <= (2*COORD_BITS+2)'(dif_s2[k][a] * dif_s2[k][a]);
				end
				if (v_s3) begin
					for (int k = 0; k < 2; k++) begin
						tot = DW'(sq_s3[k][0]) + DW'(sq_s3[k][1]) + DW'(sq_s3[k][2]);
						if (tot > best_q[k])
							best_q[k] <= tot;
					end
				end
				rn_q <= best_q;
				for (int k = 0; k < 2; k++) begin
					rr_q[k] <= '0;
					ra_q[k] <= '0;
				end
				sstep_q <= ($clog2(SQ_STEPS+1))'(SQ_STEPS);
			end
			BK_SQRT: begin
				// restoring root, one result bit a cycle; rr_q holds remainder
				for (int k = 0; k < 2; k++) begin
					tr = {rr_q[k], rn_q[k][DW-1 -: 2]} - {ra_q[k], 2'b01};
					if (!tr[DW+1] && ({rr_q[k], rn_q[k][DW-1 -: 2]} >= {ra_q[k], 2'b01})) begin
						rr_q[k] <= RW'(tr);
						ra_q[k] <= {ra_q[k][RW-2:0], 1'b1};
					end else begin
						rr_q[k] <= RW'({rr_q[k], rn_q[k][DW-1 -: 2]});
						ra_q[k] <= {ra_q[k][RW-2:0], 1'b0};
					end
					rn_q[k] <= {rn_q[k][DW-3:0], 2'b00};
				end
				sstep_q <= sstep_q - 1'b1;
			end
			default: ;
		endcase
	end
endmodule

FILE: rtl/core/mesh_bounding_sphere_top.sv
// ----------------------------------------------------------------------------
// mesh_bounding_sphere_top
// bounding sphere of a point set: mean centre or box centre, smaller radius
// ----------------------------------------------------------------------------
// points are taken one per cycle; a set's result follows its last point after
// a hand-over step, the divider steps, the scan of the store (one store read
// a cycle) and the root steps; after a last point the input is held off until
// the scan of the store ends. arst_n clears counts, sums, box, the state
// machine and the scan valid flags.
module mesh_bounding_sphere_top #(
	parameter int MAX_POINTS = mbs_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = mbs_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mbs_stream_if.sink   pt,
	mbs_stream_if.source res
);
	import mbs_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int SW = COORD_BITS + CW;

	logic                         we;
	logic [AW-1:0]                waddr, raddr;
	logic [3*COORD_BITS-1:0]      wdata, rdata;
	logic                         set_valid, set_ready, set_ovf;
	logic [CW-1:0]                set_count;
	logic signed [SW-1:0]         set_sum [3];
	logic signed [COORD_BITS-1:0] set_min [3];
	logic signed [COORD_BITS-1:0] set_max [3];

	mbs_front #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(pt.valid), .in_ready(pt.ready),
		.px(pt.data.pos_x), .py(pt.data.pos_y), .pz(pt.data.pos_z),
		.plast(pt.data.last_point),
		.we, .waddr, .wdata,
		.set_valid, .set_ready, .set_count, .set_sum, .set_min, .set_max, .set_ovf
	);

	mbs_ram #(.WIDTH(3*COORD_BITS), .DEPTH(1 << AW)) u_store (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	mbs_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
		.clk, .arst_n,
		.set_valid, .set_ready, .set_count, .set_sum, .set_min, .set_max, .set_ovf,
		.raddr, .rdata,
		.out_valid(res.valid), .out_ready(res.ready),
		.cx(res.data.center_x), .cy(res.data.center_y), .cz(res.data.center_z),
		.rad(res.data.radius), .used_box(res.data.used_box_center),
		.ovf(res.data.set_overflow)
	);
endmodule
